// ----- hdl/ring_block_cache_allocator_unit_macros.svh -----
// Assertion macros for the ring block cache allocator.
`ifndef RING_BLOCK_CACHE_ALLOCATOR_UNIT_MACROS_SVH
`define RING_BLOCK_CACHE_ALLOCATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define RBCA_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define RBCA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define RBCA_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RBCA_ASSERT_NOW(label, cond, msg)
`define RBCA_ASSERT_IMP(label, ante, cons, msg)
`define RBCA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/rbca_pkg.sv -----
package rbca_pkg;

    localparam int DEF_NUM_BLOCKS     = 4096;
    localparam int DEF_BLOCK_BYTES    = 256;
    localparam int DEF_RECENT_ENTRIES = 5;
    localparam int HEADER_BYTES       = 16;
    localparam int OFFSET_W           = 20;
    localparam int KEY_W              = 32;
    localparam int LEN_BYTES_W        = 24;

    localparam logic ACT_ALLOC  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic                   action;
        logic [KEY_W-1:0]       key_high;
        logic [KEY_W-1:0]       key_low;
        logic [LEN_BYTES_W-1:0] length_bytes;
    } req_t;

    typedef struct packed {
        logic                success;
        logic [OFFSET_W-1:0] data_offset;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ANEED,
        S_ARDF,
        S_ALATF,
        S_ACHK,
        S_ARDE,
        S_AADD,
        S_AFIN,
        S_ASPLIT,
        S_SREC,
        S_SRD,
        S_SCHK,
        S_OUT
    } state_t;

endpackage

// ----- hdl/ring_block_cache_allocator_unit.sv -----
// Ring block cache allocator.
// req channel (valid/ready) carries one item: action (allocate or search), a
// two-word key and, for allocate, the payload length in bytes. rsp channel
// (valid/ready) returns one item per request: success and the payload byte
// offset of the run (zero on failure or miss).
// One request is worked at a time; req_ready is high only while idle.
// The time from the accepting edge to rsp_valid is set by the walk over the
// run header memory, a single-port memory with registered reads: an allocate
// walks the free runs, absorbing runs and wrapping to block 0 as needed, then
// claims one and may split off a remainder; a too-large allocate fails with no
// walk. Search tries the recent list and on a miss walks the chain. The next
// request is taken the cycle after its predecessor's result is registered.
// BLOCK_BYTES must be a power of two.
// After reset the buffer is one free run of NUM_BLOCKS blocks at block 0 and
// the recent list holds key zero at block 0; no clearing pass is needed.
// A finished result is held in the output register until rsp_ready; a new
// request may be accepted meanwhile and its result waits behind it.
module ring_block_cache_allocator_unit #(
    parameter int NUM_BLOCKS     = rbca_pkg::DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES    = rbca_pkg::DEF_BLOCK_BYTES,
    parameter int RECENT_ENTRIES = rbca_pkg::DEF_RECENT_ENTRIES
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  rbca_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output rbca_pkg::rsp_t rsp
);
    import rbca_pkg::*;
    `include "ring_block_cache_allocator_unit_macros.svh"

    localparam int IW = $clog2(NUM_BLOCKS);
    localparam int LW = IW + 1;
    localparam int CW = IW + 2;
    localparam int GW = IW + 3;
    localparam int BS = $clog2(BLOCK_BYTES);
    localparam int RW = (RECENT_ENTRIES > 1) ? $clog2(RECENT_ENTRIES) : 1;
    localparam int NW = LEN_BYTES_W + 2;

    localparam logic [LW-1:0] LEN_FULL  = LW'(NUM_BLOCKS);
    localparam logic [CW-1:0] CUR_LIMIT = CW'(NUM_BLOCKS);
    localparam logic [GW-1:0] GUARD_MAX = GW'(2 * NUM_BLOCKS + 4);

    // header memories
    logic [LW-1:0]    len_mem [NUM_BLOCKS];
    logic [KEY_W-1:0] kh_mem  [NUM_BLOCKS];
    logic [KEY_W-1:0] kl_mem  [NUM_BLOCKS];

    logic [IW-1:0]    mem_addr;
    logic             len_we, kh_we, kl_we;
    logic [LW-1:0]    len_wd;
    logic [KEY_W-1:0] kh_wd;
    logic [KEY_W-1:0] kl_wd;
    logic [LW-1:0]    len_q;
    logic [KEY_W-1:0] kh_q;
    logic [KEY_W-1:0] kl_q;
    logic [IW-1:0]    addr_q;
    logic             len0_wr_reg, kh0_wr_reg;
    logic [LW-1:0]    len_rd;
    logic [KEY_W-1:0] kh_rd;

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[mem_addr] <= len_wd;
        end
        if (kh_we)
        begin
            kh_mem[mem_addr] <= kh_wd;
        end
        if (kl_we)
        begin
            kl_mem[mem_addr] <= kl_wd;
        end
        len_q  <= len_mem[mem_addr];
        kh_q   <= kh_mem[mem_addr];
        kl_q   <= kl_mem[mem_addr];
        addr_q <= mem_addr;
    end

    // length and upper key word of entry 0 read as their reset values until first written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len0_wr_reg <= 1'b0;
            kh0_wr_reg  <= 1'b0;
        end
        else
        begin
            if (len_we && mem_addr == '0)
            begin
                len0_wr_reg <= 1'b1;
            end
            if (kh_we && mem_addr == '0)
            begin
                kh0_wr_reg <= 1'b1;
            end
        end
    end

    assign len_rd = (addr_q == '0 && !len0_wr_reg) ? LEN_FULL : len_q;
    assign kh_rd  = (addr_q == '0 && !kh0_wr_reg) ? '0 : kh_q;

    // control and datapath registers
    state_t           state_reg, state_next;
    req_t             req_reg, req_next;
    logic [IW-1:0]    f_reg, f_next;
    logic [LW-1:0]    cur_len_reg, cur_len_next;
    logic [LW-1:0]    need_reg, need_next;
    logic [GW-1:0]    guard_reg, guard_next;
    logic [CW-1:0]    cur_reg, cur_next;
    logic [CW-1:0]    steps_reg, steps_next;
    logic [IW-1:0]    free_reg, free_next;
    logic [RW-1:0]    slot_reg, slot_next;
    rsp_t             res_reg, res_next;
    logic             rsp_valid_reg, rsp_valid_next;
    rsp_t             rsp_reg, rsp_next;

    logic [KEY_W-1:0] rk_high_reg [RECENT_ENTRIES];
    logic [KEY_W-1:0] rk_low_reg  [RECENT_ENTRIES];
    logic [IW-1:0]    rstart_reg  [RECENT_ENTRIES];
    logic             log_we;
    logic [IW-1:0]    log_start;

    logic [NW-1:0]    need_full;
    logic [IW:0]      end_sum;
    logic [IW:0]      fit_sum;
    logic [CW-1:0]    walk_sum;
    logic             rec_hit;
    logic [IW-1:0]    rec_start;

    function automatic logic [OFFSET_W-1:0] offset_of(input logic [IW-1:0] start);
        logic [63:0] w;
        w = (64'(start) << BS) + 64'(HEADER_BYTES);
        return w[OFFSET_W-1:0];
    endfunction

    assign need_full = (NW'(req_reg.length_bytes) + NW'(HEADER_BYTES) + NW'(BLOCK_BYTES - 1))
                       >> BS;
    assign end_sum   = (IW+1)'(f_reg) + cur_len_reg;
    assign fit_sum   = (IW+1)'(f_reg) + need_reg;
    assign walk_sum  = cur_reg + CW'(len_rd);

    always_comb
    begin
        rec_hit   = 1'b0;
        rec_start = '0;
        for (int i = RECENT_ENTRIES - 1; i >= 0; i--)
        begin
            if (rk_high_reg[i] == req_reg.key_high && rk_low_reg[i] == req_reg.key_low)
            begin
                rec_hit   = 1'b1;
                rec_start = rstart_reg[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        f_next         = f_reg;
        cur_len_next   = cur_len_reg;
        need_next      = need_reg;
        guard_next     = guard_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        free_next      = free_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mem_addr       = f_reg;
        len_we         = 1'b0;
        kh_we          = 1'b0;
        kl_we          = 1'b0;
        len_wd         = '0;
        kh_wd          = '0;
        kl_wd          = '0;
        log_we         = 1'b0;
        log_start      = f_reg;
        req_ready      = (state_reg == S_IDLE);

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    res_next   = '0;
                    state_next = (req.action == ACT_SEARCH) ? S_SREC : S_ANEED;
                end
            end
            S_ANEED:
            begin
                need_next  = LW'(need_full);
                guard_next = '0;
                f_next     = free_reg;
                if (need_full > NW'(NUM_BLOCKS))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_ARDF;
                end
            end
            S_ARDF:
            begin
                mem_addr   = f_reg;
                state_next = S_ALATF;
            end
            S_ALATF:
            begin
                cur_len_next = len_rd;
                state_next   = S_ACHK;
            end
            S_ACHK:
            begin
                if (cur_len_reg >= need_reg)
                begin
                    state_next = S_AFIN;
                end
                else if (cur_len_reg == '0 || guard_reg + GW'(1) > GUARD_MAX)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    guard_next = guard_reg + GW'(1);
                    if (end_sum >= (IW+1)'(NUM_BLOCKS))
                    begin
                        f_next     = '0;
                        mem_addr   = '0;
                        kh_we      = 1'b1;
                        kh_wd      = '0;
                        state_next = S_ARDF;
                    end
                    else
                    begin
                        state_next = S_ARDE;
                    end
                end
            end
            S_ARDE:
            begin
                mem_addr   = end_sum[IW-1:0];
                state_next = S_AADD;
            end
            S_AADD:
            begin
                cur_len_next = cur_len_reg + len_rd;
                mem_addr     = f_reg;
                len_we       = 1'b1;
                len_wd       = cur_len_reg + len_rd;
                state_next   = S_ACHK;
            end
            S_AFIN:
            begin
                mem_addr = f_reg;
                len_we   = 1'b1;
                len_wd   = need_reg;
                kh_we    = 1'b1;
                kh_wd    = req_reg.key_high;
                kl_we    = 1'b1;
                kl_wd    = req_reg.key_low;
                log_we   = 1'b1;
                log_start = f_reg;
                res_next.success     = 1'b1;
                res_next.data_offset = offset_of(f_reg);
                if (fit_sum >= (IW+1)'(NUM_BLOCKS))
                begin
                    free_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    free_next  = fit_sum[IW-1:0];
                    state_next = (cur_len_reg > need_reg) ? S_ASPLIT : S_OUT;
                end
            end
            S_ASPLIT:
            begin
                mem_addr   = free_reg;
                len_we     = 1'b1;
                len_wd     = cur_len_reg - need_reg;
                kh_we      = 1'b1;
                kh_wd      = '0;
                state_next = S_OUT;
            end
            S_SREC:
            begin
                if (rec_hit)
                begin
                    res_next.success     = 1'b1;
                    res_next.data_offset = offset_of(rec_start);
                    state_next           = S_OUT;
                end
                else
                begin
                    cur_next   = '0;
                    steps_next = '0;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                mem_addr   = cur_reg[IW-1:0];
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (kh_rd == req_reg.key_high && kl_q == req_reg.key_low)
                begin
                    log_we               = 1'b1;
                    log_start            = cur_reg[IW-1:0];
                    res_next.success     = 1'b1;
                    res_next.data_offset = offset_of(cur_reg[IW-1:0]);
                    state_next           = S_OUT;
                end
                else if (len_rd == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cur_next   = walk_sum;
                    steps_next = steps_reg + CW'(1);
                    if (walk_sum >= CUR_LIMIT || steps_reg + CW'(1) > CUR_LIMIT)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign slot_next = (32'(slot_reg) + 1 >= RECENT_ENTRIES) ? '0 : slot_reg + RW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_reg      <= '0;
            slot_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < RECENT_ENTRIES; i++)
            begin
                rk_high_reg[i] <= '0;
                rk_low_reg[i]  <= '0;
                rstart_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            rsp_valid_reg <= rsp_valid_next;
            if (log_we)
            begin
                rk_high_reg[slot_reg] <= req_reg.key_high;
                rk_low_reg[slot_reg]  <= req_reg.key_low;
                rstart_reg[slot_reg]  <= log_start;
                slot_reg              <= slot_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        f_reg       <= f_next;
        cur_len_reg <= cur_len_next;
        need_reg    <= need_next;
        guard_reg   <= guard_next;
        cur_reg     <= cur_next;
        steps_reg   <= steps_next;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `RBCA_ASSERT_NOW(a_slot_range, 32'(slot_reg) < RECENT_ENTRIES, "recent slot out of range")
    `RBCA_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "item taken while busy")
    `RBCA_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp.success, rsp.data_offset == '0,
        "failed item carries an offset")
    `RBCA_ASSERT_IMP(a_fit_before_fin, state_reg == S_AFIN, cur_len_reg >= need_reg,
        "run tagged before it fits")

endmodule

// ----- tb/sv/tb_ring_block_cache_allocator_unit.sv -----
`timescale 1ns / 1ps

module tb_ring_block_cache_allocator_unit;
    import rbca_pkg::*;

    localparam int NBLK      = DEF_NUM_BLOCKS;
    localparam int BLK_BYTES = DEF_BLOCK_BYTES;
    localparam int NREC      = DEF_RECENT_ENTRIES;
    localparam int RAND_ITEMS = 1080;
    localparam int IDLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t e;
    } row_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    // shadow of the header memory and recent list
    bit [12:0] run_len   [NBLK];
    bit [31:0] run_khi   [NBLK];
    bit [31:0] run_klo   [NBLK];
    bit [11:0] free_start;
    bit [31:0] rec_khi   [NREC];
    bit [31:0] rec_klo   [NREC];
    bit [11:0] rec_start [NREC];
    bit [2:0]  rec_slot;

    rsp_t      pending_rsp[$];
    bit [63:0] key_pool[$];
    int        err_cnt;
    int        idle_cycles;
    int        burst_left;
    int        n_alloc;
    int        n_search;
    int        n_ok;
    int        n_rsp;
    int        ready_mode;
    int        ready_phase;

    ring_block_cache_allocator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic bit [19:0] run_offset(int start);
        return 20'((start * BLK_BYTES + HEADER_BYTES) & 32'hFFFFF);
    endfunction

    function automatic void note_recent(bit [31:0] khi, bit [31:0] klo, int start);
        if (rec_slot >= NREC)
            rec_slot = '0;
        rec_khi[rec_slot]   = khi;
        rec_klo[rec_slot]   = klo;
        rec_start[rec_slot] = 12'(start);
        rec_slot = rec_slot + 3'd1;
        if (rec_slot >= NREC)
            rec_slot = '0;
    endfunction

    function automatic rsp_t claim_run(bit [31:0] khi, bit [31:0] klo, bit [23:0] nbytes);
        rsp_t r;
        int   need;
        int   f;
        int   guard;
        int   run_end;
        int   nxt;
        r = '0;
        need = (int'(nbytes) + HEADER_BYTES + BLK_BYTES - 1) / BLK_BYTES;
        if (need > NBLK)
            return r;
        f = int'(free_start);
        guard = 0;
        while (int'(run_len[f]) < need)
        begin
            if (run_len[f] == 0)
                return r;
            guard++;
            if (guard > 2 * NBLK + 4)
                return r;
            run_end = f + int'(run_len[f]);
            if (run_end >= NBLK)
            begin
                f = 0;
                run_khi[0] = '0;
            end
            else
                run_len[f] = run_len[f] + run_len[run_end];
        end
        run_khi[f] = khi;
        run_klo[f] = klo;
        if (f + need >= NBLK)
            nxt = 0;
        else
        begin
            nxt = f + need;
            if (int'(run_len[f]) > need)
            begin
                run_khi[nxt] = '0;
                run_len[nxt] = 13'(int'(run_len[f]) - need);
            end
        end
        run_len[f] = 13'(need);
        note_recent(khi, klo, f);
        free_start = 12'(nxt);
        r.success = 1'b1;
        r.data_offset = run_offset(f);
        return r;
    endfunction

    function automatic rsp_t find_run(bit [31:0] khi, bit [31:0] klo);
        rsp_t r;
        int   cur;
        int   steps;
        r = '0;
        for (int i = 0; i < NREC; i++)
        begin
            if (rec_khi[i] == khi && rec_klo[i] == klo)
            begin
                r.success = 1'b1;
                r.data_offset = run_offset(int'(rec_start[i]));
                return r;
            end
        end
        cur = 0;
        steps = 0;
        while (cur < NBLK && steps <= NBLK)
        begin
            if (run_khi[cur] == khi && run_klo[cur] == klo)
            begin
                note_recent(khi, klo, cur);
                r.success = 1'b1;
                r.data_offset = run_offset(cur);
                return r;
            end
            if (run_len[cur] == 0)
                break;
            cur += int'(run_len[cur]);
            steps++;
        end
        return r;
    endfunction

    function automatic rsp_t predict_rsp(req_t r);
        rsp_t e;
        if (r.action == ACT_ALLOC)
        begin
            n_alloc++;
            e = claim_run(r.key_high, r.key_low, r.length_bytes);
            if (e.success)
            begin
                key_pool.push_back({r.key_high, r.key_low});
                if (key_pool.size() > 16)
                    void'(key_pool.pop_front());
            end
        end
        else
        begin
            n_search++;
            e = find_run(r.key_high, r.key_low);
        end
        if (e.success)
            n_ok++;
        return e;
    endfunction

    task automatic send_item(req_t r, bit typed, rsp_t e);
        rsp_t exp_rsp;
        int   gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        req_valid <= 1'b1;
        req <= r;
        do
            @(negedge clk);
        while (!req_ready);
        exp_rsp = predict_rsp(r);
        pending_rsp.push_back(typed ? e : exp_rsp);
        @(posedge clk);
        burst_left--;
    endtask

    function automatic row_t mk_row(logic act, bit [31:0] khi, bit [31:0] klo,
                                    bit [23:0] nbytes, bit typed, bit ok, bit [19:0] offs);
        row_t w;
        w.r.action = act;
        w.r.key_high = khi;
        w.r.key_low = klo;
        w.r.length_bytes = nbytes;
        w.typed = typed;
        w.e.success = ok;
        w.e.data_offset = offs;
        return w;
    endfunction

    function automatic req_t rand_item();
        req_t      r;
        bit [63:0] k;
        int        pick;
        r.action = ($urandom_range(0, 99) < 55) ? ACT_ALLOC : ACT_SEARCH;
        r.key_high = $urandom;
        r.key_low = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 85)
            r.length_bytes = 24'($urandom_range(0, 2000));
        else if (pick < 95)
            r.length_bytes = 24'($urandom_range(0, 70000));
        else
            r.length_bytes = 24'($urandom);
        if (r.action == ACT_SEARCH)
        begin
            if (key_pool.size() > 0 && $urandom_range(0, 99) < 65)
            begin
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                r.key_high = k[63:32];
                r.key_low = k[31:0];
            end
            // a zero upper word could reach a free run with an unwritten lower word
            if (r.key_high == '0)
                r.key_high = 32'h1;
        end
        else if ($urandom_range(0, 19) == 0)
            r.key_high = '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            ready_mode <= 0;
            ready_phase <= 0;
        end
        else
        begin
            if (ready_phase == 0)
            begin
                ready_mode <= $urandom_range(0, 3);
                ready_phase <= $urandom_range(8, 80);
            end
            else
                ready_phase <= ready_phase - 1;
            case (ready_mode)
                0: rsp_ready <= 1'b1;
                1: rsp_ready <= ($urandom_range(0, 1) == 0);
                2: rsp_ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ready <= (ready_phase[2:0] != 3'd0);
            endcase
        end
    end

    always @(negedge clk)
    begin
        rsp_t e;
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            if (rsp_valid && rsp_ready)
            begin
                n_rsp++;
                if (pending_rsp.size() == 0)
                begin
                    $error("result item with nothing expected");
                    err_cnt++;
                end
                else
                begin
                    e = pending_rsp.pop_front();
                    if (rsp.success !== e.success)
                    begin
                        $error("success: expected %0d, got %0d", e.success, rsp.success);
                        err_cnt++;
                    end
                    if (rsp.data_offset !== e.data_offset)
                    begin
                        $error("data_offset: expected 0x%05h, got 0x%05h",
                               e.data_offset, rsp.data_offset);
                        err_cnt++;
                    end
                end
            end
        end
    end

    initial
    begin
        row_t dir_rows[];
        rsp_t none;
        for (int i = 0; i < NBLK; i++)
        begin
            run_len[i] = '0;
            run_khi[i] = '0;
            run_klo[i] = '0;
        end
        run_len[0] = 13'(NBLK);
        free_start = '0;
        for (int i = 0; i < NREC; i++)
        begin
            rec_khi[i] = '0;
            rec_klo[i] = '0;
            rec_start[i] = '0;
        end
        rec_slot = '0;
        err_cnt = 0;
        idle_cycles = 0;
        burst_left = 0;
        n_alloc = 0;
        n_search = 0;
        n_ok = 0;
        n_rsp = 0;
        none = '0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;

        dir_rows = '{
            mk_row(ACT_SEARCH, 32'h0, 32'h0, 24'h0, 1'b1, 1'b1, 20'd16),
            mk_row(ACT_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'h1, 32'h2, 24'd1048561, 1'b1, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'hA5A5A5A5, 32'h5A5A5A5A, 24'd0, 1'b1, 1'b1, 20'd16),
            mk_row(ACT_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'd240, 1'b1, 1'b1, 20'd272),
            mk_row(ACT_ALLOC, 32'h5A5A5A5A, 32'h0, 24'd241, 1'b1, 1'b1, 20'd528),
            mk_row(ACT_SEARCH, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 1'b1, 1'b1, 20'd272),
            mk_row(ACT_SEARCH, 32'h1, 32'h5, 24'h0, 1'b1, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'h0, 32'h12345678, 24'd100, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'h0BADF00D, 32'h1, 24'd1047536, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'hC0FFEE00, 32'h3, 24'd0, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'h77, 32'h88, 24'd752, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_SEARCH, 32'hA5A5A5A5, 32'h5A5A5A5A, 24'h0, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_SEARCH, 32'h5A5A5A5A, 32'h0, 24'h0, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'hDEAD, 32'hBEEF, 24'd1047792, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'hFEED, 32'hFACE, 24'd1048560, 1'b1, 1'b1, 20'd16),
            mk_row(ACT_SEARCH, 32'hFEED, 32'hFACE, 24'h0, 1'b1, 1'b1, 20'd16),
            mk_row(ACT_SEARCH, 32'hDEAD, 32'hBEEF, 24'h0, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_SEARCH, 32'h0BADF00D, 32'h1, 24'h0, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_ALLOC, 32'h1234, 32'h5678, 24'd3000, 1'b0, 1'b0, 20'd0),
            mk_row(ACT_SEARCH, 32'h1234, 32'h5678, 24'h0, 1'b0, 1'b0, 20'd0)
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].e);
        for (int i = 0; i < RAND_ITEMS; i++)
            send_item(rand_item(), 1'b0, none);
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d allocates and %0d searches, %0d results, %0d successful",
                 n_alloc, n_search, n_rsp, n_ok);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- ring_block_cache_allocator_unit.f -----
+incdir+hdl
hdl/rbca_pkg.sv
hdl/ring_block_cache_allocator_unit.sv
tb/sv/tb_ring_block_cache_allocator_unit.sv
